FILE: hw/rtl/spt_pkg.sv
// Shared types and constants for the signal persistence track table.
`timescale 1ns / 1ps
`default_nettype none
package spt_pkg;

  // Input item
  typedef struct packed {
    logic               cmd;
    logic        [32:0] freq_hz;
    logic signed [15:0] power;
  } in_item_t;

  // Result item
  typedef struct packed {
    logic               kind;
    logic        [1:0]  status;
    logic        [5:0]  slot;
    logic        [15:0] hit_count;
    logic        [32:0] freq_out;
    logic signed [15:0] power_out;
    logic        [2:0]  rank;
    logic        [6:0]  active_count;
    logic        [6:0]  persistent_count;
    logic        [2:0]  activity_level;
    logic               last;
  } out_item_t;

  // One table entry as held by a cell
  typedef struct packed {
    logic        valid;
    logic        seen;
    logic        active;
    logic [32:0] key;
    logic [15:0] power;
    logic [15:0] hits;
    logic [7:0]  misses;
  } entry_t;

  // Commands and result codes
  localparam logic CMD_DETECT = 1'b0;
  localparam logic CMD_SCAN   = 1'b1;

  localparam logic KIND_ACK    = 1'b0;
  localparam logic KIND_REPORT = 1'b1;

  localparam logic [1:0] ST_UPDATED  = 2'd0;
  localparam logic [1:0] ST_INSERTED = 2'd1;
  localparam logic [1:0] ST_DROPPED  = 2'd2;
  localparam logic [1:0] ST_ENTRY    = 2'd0;
  localparam logic [1:0] ST_NONE     = 2'd1;

  // Register indexes
  localparam logic [1:0] REG_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_PRUNE     = 2'd1;
  localparam logic [1:0] REG_REPORT    = 2'd2;

  // Register reset values
  localparam logic [7:0] THRESHOLD_RESET = 8'd3;
  localparam logic [7:0] PRUNE_RESET     = 8'd10;
  localparam logic [3:0] REPORT_RESET    = 4'd5;

  // Activity level bounds
  localparam int unsigned LEVEL_LIGHT    = 10;
  localparam int unsigned LEVEL_MODERATE = 30;
  localparam int unsigned LEVEL_HIGH     = 60;

  localparam logic [2:0] LVL_NONE     = 3'd0;
  localparam logic [2:0] LVL_LIGHT    = 3'd1;
  localparam logic [2:0] LVL_MODERATE = 3'd2;
  localparam logic [2:0] LVL_HIGH     = 3'd3;
  localparam logic [2:0] LVL_HEAVY    = 3'd4;

endpackage
`default_nettype wire

FILE: hw/rtl/spt_cell.sv
// One table cell: holds an entry, shifts toward the head, takes direct inserts.
`timescale 1ns / 1ps
`default_nettype none
module spt_cell (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            shift_i,
  input  wire spt_pkg::entry_t shift_in_i,
  input  wire logic            wr_i,
  input  wire spt_pkg::entry_t wr_data_i,
  output spt_pkg::entry_t      entry_o
);
  import spt_pkg::*;

  entry_t entry_q;
  entry_t entry_d;

  // Next contents
  always_comb begin
    entry_d = entry_q;
    if (shift_i) begin
      entry_d = shift_in_i;
    end else if (wr_i) begin
      entry_d = wr_data_i;
    end
  end

  // Entry register, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

  assign entry_o = entry_q;

endmodule
`default_nettype wire

FILE: hw/rtl/spt_rank.sv
// Sorted list of the strongest active entries, filled one entry per cycle.
`timescale 1ns / 1ps
`default_nettype none
module spt_rank #(
  parameter int unsigned SW      = 6,
  parameter int unsigned TOP_MAX = 8,
  parameter int unsigned RW      = 3,
  parameter int unsigned CNTW    = 4
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               clr_i,
  input  wire logic               ins_i,
  input  wire logic [SW-1:0]      ins_slot_i,
  input  wire logic [15:0]        ins_hits_i,
  input  wire logic [32:0]        ins_key_i,
  input  wire logic signed [15:0] ins_power_i,
  input  wire logic [RW-1:0]      rd_idx_i,
  output logic [SW-1:0]           rd_slot_o,
  output logic [15:0]             rd_hits_o,
  output logic [32:0]             rd_key_o,
  output logic signed [15:0]      rd_power_o,
  output logic [CNTW-1:0]         count_o
);

  logic [SW-1:0]      slot_q  [TOP_MAX];
  logic [15:0]        hits_q  [TOP_MAX];
  logic [32:0]        key_q   [TOP_MAX];
  logic signed [15:0] power_q [TOP_MAX];
  logic [CNTW-1:0]    count_q;
  logic [CNTW-1:0]    pos;

  // Insert position: after every held entry of equal or higher power
  always_comb begin
    pos = '0;
    for (int j = 0; j < TOP_MAX; j++) begin
      if ((CNTW'(j) < count_q) && (power_q[j] >= ins_power_i)) begin
        pos = pos + CNTW'(1);
      end
    end
  end

  // List body
  always_ff @(posedge clk_i) begin
    if (ins_i) begin
      for (int j = 0; j < TOP_MAX; j++) begin
        if (CNTW'(j) == pos) begin
          slot_q[j]  <= ins_slot_i;
          hits_q[j]  <= ins_hits_i;
          key_q[j]   <= ins_key_i;
          power_q[j] <= ins_power_i;
        end else if ((CNTW'(j) > pos) && (j > 0)) begin
          slot_q[j]  <= slot_q[j-1];
          hits_q[j]  <= hits_q[j-1];
          key_q[j]   <= key_q[j-1];
          power_q[j] <= power_q[j-1];
        end
      end
    end
  end

  // Fill count, saturating at the list length
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (clr_i) begin
      count_q <= '0;
    end else if (ins_i && (count_q != CNTW'(TOP_MAX))) begin
      count_q <= count_q + CNTW'(1);
    end
  end

  assign rd_slot_o  = slot_q[rd_idx_i];
  assign rd_hits_o  = hits_q[rd_idx_i];
  assign rd_key_o   = key_q[rd_idx_i];
  assign rd_power_o = power_q[rd_idx_i];
  assign count_o    = count_q;

endmodule
`default_nettype wire

FILE: hw/rtl/signal_persistence_track_table.sv
// Top level: ring of table cells, head update logic, ranking list, result register.
// Each item takes one pass in which the ring rotates once through the head logic;
// the results are then produced in the emit state and held in the result register.
// Results then leave one per cycle unless stalled: a detection gives one result,
// an end of scan 1 to TOP_MAX; the next item is taken once the last result of the
// previous one is registered. Reset clears every cell at once; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module signal_persistence_track_table #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned TOP_MAX     = 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire spt_pkg::in_item_t   in_item_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output spt_pkg::out_item_t       out_item_o,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [3:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output logic [31:0]              prdata,
  output logic                     pready
);
  import spt_pkg::*;

  localparam int unsigned SW   = $clog2(TABLE_DEPTH);
  localparam int unsigned CW   = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned RW   = (TOP_MAX > 1) ? $clog2(TOP_MAX) : 1;
  localparam int unsigned CNTW = $clog2(TOP_MAX + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_PASS,
    S_EMIT
  } state_e;

  state_e          state_q;
  logic [SW-1:0]   pos_q;
  in_item_t        item_q;
  logic            hit_q;
  logic [SW-1:0]   hit_slot_q;
  logic [15:0]     hit_cnt_q;
  logic            free_q;
  logic [SW-1:0]   free_slot_q;
  logic [CW-1:0]   act_q;
  logic [CW-1:0]   pers_q;
  logic [RW-1:0]   emit_q;
  logic            out_valid_q;
  out_item_t       out_item_q;
  out_item_t       out_item_d;
  logic [7:0]      thr_q;
  logic [7:0]      prune_q;
  logic [3:0]      rep_q;

  entry_t          cell_q [TABLE_DEPTH];
  entry_t          head_e;
  entry_t          ins_e;
  logic            shift_en;
  logic            ins_en;
  logic            hit_now;
  logic            free_now;
  logic            count_en;
  logic            pers_en;
  logic [7:0]      miss_n;
  logic            accept;
  logic            out_free;
  logic            emit_fire;
  logic [SW-1:0]   rk_slot;
  logic [15:0]     rk_hits;
  logic [32:0]     rk_key;
  logic signed [15:0] rk_power;
  logic [CNTW-1:0] rk_cnt;
  logic [CNTW-1:0] rep_lim;
  logic [CNTW-1:0] num;
  logic [6:0]      act_sat;
  logic [6:0]      pers_sat;
  logic [2:0]      level;
  logic            cfg_wr;

  assign accept    = in_valid_i && (state_q == S_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign shift_en  = (state_q == S_PASS);
  assign emit_fire = (state_q == S_EMIT) && out_free;

  // Configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_comb begin
    unique case (paddr[3:2])
      REG_THRESHOLD: prdata = {24'd0, thr_q};
      REG_PRUNE:     prdata = {24'd0, prune_q};
      REG_REPORT:    prdata = {28'd0, rep_q};
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q   <= THRESHOLD_RESET;
      prune_q <= PRUNE_RESET;
      rep_q   <= REPORT_RESET;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        REG_THRESHOLD: thr_q   <= pwdata[7:0];
        REG_PRUNE:     prune_q <= pwdata[7:0];
        REG_REPORT:    rep_q   <= pwdata[3:0];
        default:       ;
      endcase
    end
  end

  // Head logic: updates the entry leaving cell 0 on its way to the ring tail
  always_comb begin
    head_e   = cell_q[0];
    hit_now  = 1'b0;
    free_now = 1'b0;
    count_en = 1'b0;
    pers_en  = 1'b0;
    miss_n   = cell_q[0].misses;
    if (state_q == S_PASS) begin
      if (item_q.cmd == CMD_DETECT) begin
        if (cell_q[0].valid && (cell_q[0].key == item_q.freq_hz) && !hit_q) begin
          hit_now       = 1'b1;
          head_e.power  = item_q.power;
          head_e.hits   = (cell_q[0].hits == 16'hFFFF) ? 16'hFFFF
                                                       : cell_q[0].hits + 16'd1;
          head_e.misses = 8'd0;
          head_e.active = 1'b1;
          head_e.seen   = 1'b1;
        end
        free_now = !cell_q[0].valid && !free_q;
      end else begin
        // age entries not seen this scan, then prune
        if (cell_q[0].valid && !cell_q[0].seen) begin
          miss_n = (cell_q[0].misses == 8'hFF) ? 8'hFF : cell_q[0].misses + 8'd1;
          head_e.misses = miss_n;
          if (miss_n >= thr_q) begin
            head_e.active = 1'b0;
          end
        end
        head_e.seen = 1'b0;
        if (head_e.valid && !head_e.active && (miss_n > prune_q)) begin
          head_e.valid = 1'b0;
        end
        count_en = head_e.valid && head_e.active;
        pers_en  = count_en && (head_e.hits >= 16'(thr_q));
      end
    end
  end

  // Insert data for a new entry
  always_comb begin
    ins_e        = '0;
    ins_e.valid  = 1'b1;
    ins_e.seen   = 1'b1;
    ins_e.active = 1'b1;
    ins_e.key    = item_q.freq_hz;
    ins_e.power  = item_q.power;
    ins_e.hits   = 16'd1;
    ins_e.misses = 8'd0;
  end

  assign ins_en = emit_fire && (item_q.cmd == CMD_DETECT) && !hit_q && free_q;

  // Ring of cells, shifting toward cell 0
  for (genvar k = 0; k < TABLE_DEPTH; k++) begin : g_cell
    entry_t nb;
    if (k == TABLE_DEPTH - 1) begin : g_tail
      assign nb = head_e;
    end else begin : g_mid
      assign nb = cell_q[k+1];
    end
    spt_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_i    (shift_en),
      .shift_in_i (nb),
      .wr_i       (ins_en && (free_slot_q == SW'(k))),
      .wr_data_i  (ins_e),
      .entry_o    (cell_q[k])
    );
  end

  // Strongest active entries
  spt_rank #(
    .SW      (SW),
    .TOP_MAX (TOP_MAX),
    .RW      (RW),
    .CNTW    (CNTW)
  ) u_rank (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clr_i       (accept),
    .ins_i       (count_en),
    .ins_slot_i  (pos_q),
    .ins_hits_i  (head_e.hits),
    .ins_key_i   (head_e.key),
    .ins_power_i (head_e.power),
    .rd_idx_i    (emit_q),
    .rd_slot_o   (rk_slot),
    .rd_hits_o   (rk_hits),
    .rd_key_o    (rk_key),
    .rd_power_o  (rk_power),
    .count_o     (rk_cnt)
  );

  // Report counts and level
  always_comb begin
    rep_lim  = (32'(rep_q) > TOP_MAX) ? CNTW'(TOP_MAX) : CNTW'(rep_q);
    num      = (rk_cnt < rep_lim) ? rk_cnt : rep_lim;
    act_sat  = (32'(act_q) > 127) ? 7'd127 : 7'(act_q);
    pers_sat = (32'(pers_q) > 127) ? 7'd127 : 7'(pers_q);
    if (act_q == '0) begin
      level = LVL_NONE;
    end else if (32'(act_q) < LEVEL_LIGHT) begin
      level = LVL_LIGHT;
    end else if (32'(act_q) < LEVEL_MODERATE) begin
      level = LVL_MODERATE;
    end else if (32'(act_q) < LEVEL_HIGH) begin
      level = LVL_HIGH;
    end else begin
      level = LVL_HEAVY;
    end
  end

  // Next result item
  always_comb begin
    out_item_d = '0;
    if (item_q.cmd == CMD_DETECT) begin
      out_item_d.kind      = KIND_ACK;
      out_item_d.freq_out  = item_q.freq_hz;
      out_item_d.power_out = item_q.power;
      out_item_d.last      = 1'b1;
      if (hit_q) begin
        out_item_d.status    = ST_UPDATED;
        out_item_d.slot      = 6'(hit_slot_q);
        out_item_d.hit_count = hit_cnt_q;
      end else if (free_q) begin
        out_item_d.status    = ST_INSERTED;
        out_item_d.slot      = 6'(free_slot_q);
        out_item_d.hit_count = 16'd1;
      end else begin
        out_item_d.status = ST_DROPPED;
      end
    end else begin
      out_item_d.kind             = KIND_REPORT;
      out_item_d.active_count     = act_sat;
      out_item_d.persistent_count = pers_sat;
      out_item_d.activity_level   = level;
      if (num == '0) begin
        out_item_d.status = ST_NONE;
        out_item_d.last   = 1'b1;
      end else begin
        out_item_d.status    = ST_ENTRY;
        out_item_d.slot      = 6'(rk_slot);
        out_item_d.hit_count = rk_hits;
        out_item_d.freq_out  = rk_key;
        out_item_d.power_out = rk_power;
        out_item_d.rank      = 3'(emit_q);
        out_item_d.last      = ((CNTW'(emit_q) + CNTW'(1)) == num);
      end
    end
  end

  // Sequencer and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      pos_q       <= '0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      act_q       <= '0;
      pers_q      <= '0;
      emit_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        S_IDLE: begin
          if (accept) begin
            state_q <= S_PASS;
            pos_q   <= '0;
            hit_q   <= 1'b0;
            free_q  <= 1'b0;
            act_q   <= '0;
            pers_q  <= '0;
          end
        end
        S_PASS: begin
          if (hit_now) begin
            hit_q <= 1'b1;
          end
          if (free_now) begin
            free_q <= 1'b1;
          end
          if (count_en) begin
            act_q <= act_q + CW'(1);
          end
          if (pers_en) begin
            pers_q <= pers_q + CW'(1);
          end
          pos_q <= pos_q + SW'(1);
          if (pos_q == SW'(TABLE_DEPTH - 1)) begin
            state_q <= S_EMIT;
            emit_q  <= '0;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            if (item_q.cmd == CMD_DETECT) begin
              state_q <= S_IDLE;
            end else if ((num == '0) ||
                         ((CNTW'(emit_q) + CNTW'(1)) == num)) begin
              state_q <= S_IDLE;
            end else begin
              emit_q <= emit_q + RW'(1);
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // Result payload and item capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_item_i;
    end
    if (hit_now) begin
      hit_slot_q <= pos_q;
      hit_cnt_q  <= head_e.hits;
    end
    if (free_now) begin
      free_slot_q <= pos_q;
    end
    if (emit_fire) begin
      out_item_q <= out_item_d;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

endmodule
`default_nettype wire

FILE: tb/tb.sv
// Testbench for the signal persistence track table: random and directed items, scoreboard check.
`timescale 1ns / 1ps
`default_nettype none

// Scoreboard: local copy of the table, predicts results, compares accepted results
class track_scoreboard;
  bit              valid_q[64];
  bit              seen_q[64];
  bit              active_q[64];
  logic [32:0]     key_q[64];
  logic [15:0]     power_q[64];
  logic [15:0]     hits_q[64];
  logic [7:0]      misses_q[64];
  logic [7:0]      threshold;
  logic [7:0]      prune_lim;
  logic [3:0]      report_n;
  spt_pkg::out_item_t pending_q[$];
  int              errors;

  function new();
    for (int i = 0; i < 64; i++) begin
      valid_q[i] = 0; seen_q[i] = 0; active_q[i] = 0;
      key_q[i] = '0; power_q[i] = '0; hits_q[i] = '0; misses_q[i] = '0;
    end
    threshold = spt_pkg::THRESHOLD_RESET;
    prune_lim = spt_pkg::PRUNE_RESET;
    report_n  = spt_pkg::REPORT_RESET;
    errors = 0;
  endfunction

  function void set_reg(logic [1:0] idx, logic [31:0] val);
    case (idx)
      spt_pkg::REG_THRESHOLD: threshold = val[7:0];
      spt_pkg::REG_PRUNE:     prune_lim = val[7:0];
      spt_pkg::REG_REPORT:    report_n  = val[3:0];
      default: ;
    endcase
  endfunction

  // Append one expected result
  function void queue_result(spt_pkg::out_item_t r);
    pending_q = {pending_q, r};
  endfunction

  // Note an accepted input item and queue what it should produce
  function void note_item(spt_pkg::in_item_t it);
    spt_pkg::out_item_t r;
    int free_slot, act, pers, n, cnt, best;
    bit picked[64];
    logic [2:0] lvl;
    r = '0;
    if (it.cmd == spt_pkg::CMD_DETECT) begin
      free_slot = -1;
      r.kind = spt_pkg::KIND_ACK;
      r.freq_out = it.freq_hz;
      r.power_out = it.power;
      r.last = 1'b1;
      for (int i = 0; i < 64; i++) begin
        if (valid_q[i] && key_q[i] == it.freq_hz) begin
          power_q[i] = it.power;
          if (hits_q[i] != 16'hFFFF) hits_q[i]++;
          misses_q[i] = 0; active_q[i] = 1; seen_q[i] = 1;
          r.status = spt_pkg::ST_UPDATED;
          r.slot = i[5:0];
          r.hit_count = hits_q[i];
          queue_result(r);
          return;
        end
        if (!valid_q[i] && free_slot < 0) free_slot = i;
      end
      if (free_slot < 0) begin
        r.status = spt_pkg::ST_DROPPED;
      end else begin
        valid_q[free_slot] = 1; key_q[free_slot] = it.freq_hz;
        power_q[free_slot] = it.power; hits_q[free_slot] = 1;
        misses_q[free_slot] = 0; active_q[free_slot] = 1; seen_q[free_slot] = 1;
        r.status = spt_pkg::ST_INSERTED;
        r.slot = free_slot[5:0];
        r.hit_count = 16'd1;
      end
      queue_result(r);
      return;
    end
    // End of scan: age, prune, count, rank
    for (int i = 0; i < 64; i++) begin
      if (valid_q[i] && !seen_q[i]) begin
        if (misses_q[i] != 8'hFF) misses_q[i]++;
        if (misses_q[i] >= threshold) active_q[i] = 0;
      end
      seen_q[i] = 0;
      if (valid_q[i] && !active_q[i] && misses_q[i] > prune_lim) valid_q[i] = 0;
    end
    act = 0; pers = 0;
    for (int i = 0; i < 64; i++)
      if (valid_q[i] && active_q[i]) begin
        act++;
        if (hits_q[i] >= threshold) pers++;
      end
    if (act == 0) lvl = spt_pkg::LVL_NONE;
    else if (act < spt_pkg::LEVEL_LIGHT) lvl = spt_pkg::LVL_LIGHT;
    else if (act < spt_pkg::LEVEL_MODERATE) lvl = spt_pkg::LVL_MODERATE;
    else if (act < spt_pkg::LEVEL_HIGH) lvl = spt_pkg::LVL_HIGH;
    else lvl = spt_pkg::LVL_HEAVY;
    n = (report_n > 8) ? 8 : report_n;
    for (int i = 0; i < 64; i++) picked[i] = 0;
    cnt = 0;
    r.kind = spt_pkg::KIND_REPORT;
    r.active_count = act[6:0];
    r.persistent_count = pers[6:0];
    r.activity_level = lvl;
    while (cnt < n) begin
      best = -1;
      for (int i = 0; i < 64; i++) begin
        if (!valid_q[i] || !active_q[i] || picked[i]) continue;
        if (best < 0 || $signed(power_q[i]) > $signed(power_q[best])) best = i;
      end
      if (best < 0) break;
      picked[best] = 1;
      r.status = spt_pkg::ST_ENTRY;
      r.slot = best[5:0];
      r.hit_count = hits_q[best];
      r.freq_out = key_q[best];
      r.power_out = power_q[best];
      r.rank = cnt[2:0];
      r.last = 1'b0;
      queue_result(r);
      cnt++;
    end
    if (cnt == 0) begin
      r.status = spt_pkg::ST_NONE;
      r.last = 1'b1;
      queue_result(r);
    end else begin
      pending_q[$].last = 1'b1;
    end
  endfunction

  // Compare one accepted result with the oldest expectation
  function void check_result(spt_pkg::out_item_t got);
    spt_pkg::out_item_t e;
    if (pending_q.size() == 0) begin
      $error("unexpected result item %p", got);
      errors++;
      return;
    end
    e = pending_q.pop_front();
    if (got.kind !== e.kind) begin
      $error("kind exp %0d got %0d", e.kind, got.kind); errors++;
    end
    if (got.status !== e.status) begin
      $error("status exp %0d got %0d", e.status, got.status); errors++;
    end
    if (got.slot !== e.slot) begin
      $error("slot exp %0d got %0d", e.slot, got.slot); errors++;
    end
    if (got.hit_count !== e.hit_count) begin
      $error("hit_count exp %0d got %0d", e.hit_count, got.hit_count); errors++;
    end
    if (got.freq_out !== e.freq_out) begin
      $error("freq_out exp %0d got %0d", e.freq_out, got.freq_out); errors++;
    end
    if (got.power_out !== e.power_out) begin
      $error("power_out exp %0d got %0d", e.power_out, got.power_out); errors++;
    end
    if (got.rank !== e.rank) begin
      $error("rank exp %0d got %0d", e.rank, got.rank); errors++;
    end
    if (got.active_count !== e.active_count) begin
      $error("active_count exp %0d got %0d", e.active_count, got.active_count); errors++;
    end
    if (got.persistent_count !== e.persistent_count) begin
      $error("persistent_count exp %0d got %0d", e.persistent_count,
             got.persistent_count);
      errors++;
    end
    if (got.activity_level !== e.activity_level) begin
      $error("activity_level exp %0d got %0d", e.activity_level, got.activity_level);
      errors++;
    end
    if (got.last !== e.last) begin
      $error("last exp %0d got %0d", e.last, got.last); errors++;
    end
  endfunction
endclass

module tb;
  import spt_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_item_t    in_item_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b1;
  out_item_t   out_item_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  track_scoreboard sb;
  logic [32:0] freq_pool[16];
  int          hold_cycles;
  int          scan_stretch;

  signal_persistence_track_table dut (.*);

  always #1 clk_i = ~clk_i;

  // Register write, APB setup then access
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(posedge clk_i);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  // Offer one item after a random gap, hold until accepted; valid stays up
  // after acceptance until the next gap or drain, the block is busy by then
  task automatic send_item(logic cmd, logic [32:0] f, logic [15:0] p, bit no_gap = 0);
    int gap;
    in_item_t it;
    gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15));
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    it.cmd = cmd; it.freq_hz = f; it.power = p;
    in_item_i <= it;
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_item(it);
  endtask

  task automatic detect(logic [32:0] f, logic [15:0] p);
    send_item(CMD_DETECT, f, p);
  endtask

  task automatic end_scan();
    send_item(CMD_SCAN, 33'($urandom()), 16'($urandom()));
  endtask

  // Wait until every expected result has arrived, then let the block settle
  task automatic drain();
    int guard;
    in_valid_i <= 1'b0;
    guard = 0;
    while (sb.pending_q.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (140) @(posedge clk_i);
  endtask

  // Random detection: mostly from a small frequency pool so entries get hits
  task automatic random_detect();
    logic [32:0] f;
    if ($urandom_range(0, 9) < 8) f = freq_pool[$urandom_range(0, 15)];
    else f = 33'({$urandom(), $urandom()});
    detect(f, 16'($urandom()));
  endtask

  // Receiver: random stall per item, one long hold-off on request
  initial begin
    int wait_n;
    @(posedge rst_ni);
    forever begin
      if (hold_cycles > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold_cycles) @(posedge clk_i);
        hold_cycles = 0;
      end
      wait_n = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
      if (wait_n > 0) begin
        out_stall_i <= 1'b1;
        repeat (wait_n) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
      sb.check_result(out_item_o);
    end
  end

  // Timeout
  initial begin
    #4000000;
    $display("tb: failure");
    $finish;
  end

  // Stimulus
  initial begin
    rst_ni <= 1'b0;
    sb = new();
    hold_cycles = 0;
    for (int i = 0; i < 16; i++) freq_pool[i] = 33'({$urandom(), $urandom()});
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Directed: empty scan, field extremes, repeated frequency, equal power
    end_scan();
    detect('0, 16'h8000);
    detect({33{1'b1}}, 16'h7FFF);
    detect('0, 16'h0000);
    detect(33'h1_5555_5555, 16'hFFFF);
    detect(33'h0_AAAA_AAAA, 16'hFFFF);
    detect(33'h0_AAAA_AAAA, 16'h0001);
    end_scan();
    end_scan();
    drain();
    write_reg(REG_REPORT, 32'd0);
    end_scan();
    drain();
    write_reg(REG_REPORT, 32'd15);
    write_reg(REG_THRESHOLD, 32'd0);
    write_reg(REG_PRUNE, 32'd0);
    detect(33'd100, 16'h0010);
    end_scan();
    end_scan();
    end_scan();
    drain();

    // Fill the table to overflow, with a long output hold-off
    write_reg(REG_THRESHOLD, 32'd255);
    write_reg(REG_PRUNE, 32'd255);
    write_reg(REG_REPORT, 32'd8);
    hold_cycles = 400;
    for (int i = 0; i < 70; i++) send_item(CMD_DETECT, 33'h1000 + i, 16'($urandom()), 1);
    end_scan();
    drain();
    // Age with maximum threshold: entries miss scans but stay active
    for (int i = 0; i < 3; i++) end_scan();
    drain();
    write_reg(REG_THRESHOLD, 32'd1);
    write_reg(REG_PRUNE, 32'd0);
    end_scan();
    end_scan();
    drain();

    // Random phases under several settings
    for (int ph = 0; ph < 6; ph++) begin
      write_reg(REG_THRESHOLD, (ph == 0) ? 32'd1 : (ph == 1) ? 32'd255 : $urandom_range(0, 6));
      write_reg(REG_PRUNE, (ph == 2) ? 32'd255 : $urandom_range(0, 12));
      write_reg(REG_REPORT, (ph == 3) ? 32'd0 : $urandom_range(1, 15));
      for (int k = 0; k < 10; k++) begin
        scan_stretch = $urandom_range(0, 9);
        for (int d = 0; d < scan_stretch; d++) random_detect();
        end_scan();
      end
      drain();
    end

    drain();
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end
endmodule
`default_nettype wire

FILE: signal_persistence_track_table.f
hw/rtl/spt_pkg.sv
hw/rtl/spt_cell.sv
hw/rtl/spt_rank.sv
hw/rtl/signal_persistence_track_table.sv
tb/tb.sv
